// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros - assertion helpers for the token lexer
// Clocked implication checks, quiet while reset is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while reset is low.
`define STL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// Next-cycle implication, sampled on clk, quiet while reset is low.
`define STL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

// ===== src/stl_pkg.sv =====
// ---------------------------------------------------------------------------
// stl_pkg - shared types and constants for the script token lexer
// Transaction payloads, token kinds, scan modes and character helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  localparam int OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_input;
  } lex_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [1:0]  value_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } lex_out_t;

  // Token kinds
  localparam logic [3:0] TOK_END     = 4'd0;
  localparam logic [3:0] TOK_IDENT   = 4'd1;
  localparam logic [3:0] TOK_LOCAL   = 4'd2;
  localparam logic [3:0] TOK_TYPE    = 4'd3;
  localparam logic [3:0] TOK_NUMBER  = 4'd4;
  localparam logic [3:0] TOK_DECIMAL = 4'd5;
  localparam logic [3:0] TOK_ASSIGN  = 4'd6;
  localparam logic [3:0] TOK_PLUS    = 4'd7;
  localparam logic [3:0] TOK_MINUS   = 4'd8;
  localparam logic [3:0] TOK_STAR    = 4'd9;
  localparam logic [3:0] TOK_SLASH   = 4'd10;
  localparam logic [3:0] TOK_LPAREN  = 4'd11;
  localparam logic [3:0] TOK_RPAREN  = 4'd12;
  localparam logic [3:0] TOK_COLON   = 4'd13;
  localparam logic [3:0] TOK_ERROR   = 4'd14;

  // Value types
  localparam logic [1:0] VT_NONE  = 2'd0;
  localparam logic [1:0] VT_INT   = 2'd1;
  localparam logic [1:0] VT_FLOAT = 2'd2;

  // Scan modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_INT     = 3'd2;
  localparam logic [2:0] MODE_FRAC    = 3'd3;
  localparam logic [2:0] MODE_DASH    = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;

  // Keyword slots, bit positions in the match mask
  localparam logic [1:0] KW_LOCAL = 2'd0;
  localparam logic [1:0] KW_INT   = 2'd1;
  localparam logic [1:0] KW_FLOAT = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // True when keyword k holds character c at index idx.
  function automatic logic kw_hit(input logic [1:0] k, input offset_t idx,
                                  input logic [7:0] c);
    logic [7:0] ch;
    ch = CH_NUL;
    if (idx < offset_t'(5)) begin
      unique case ({k, idx[2:0]})
        {KW_LOCAL, 3'd0}: ch = 8'h6C; // l
        {KW_LOCAL, 3'd1}: ch = 8'h6F; // o
        {KW_LOCAL, 3'd2}: ch = 8'h63; // c
        {KW_LOCAL, 3'd3}: ch = 8'h61; // a
        {KW_LOCAL, 3'd4}: ch = 8'h6C; // l
        {KW_INT,   3'd0}: ch = 8'h69; // i
        {KW_INT,   3'd1}: ch = 8'h6E; // n
        {KW_INT,   3'd2}: ch = 8'h74; // t
        {KW_FLOAT, 3'd0}: ch = 8'h66; // f
        {KW_FLOAT, 3'd1}: ch = 8'h6C; // l
        {KW_FLOAT, 3'd2}: ch = 8'h6F; // o
        {KW_FLOAT, 3'd3}: ch = 8'h61; // a
        {KW_FLOAT, 3'd4}: ch = 8'h74; // t
        default:          ch = CH_NUL;
      endcase
    end
    return (ch != CH_NUL) && (ch == c);
  endfunction

  // Low 16 bits of an offset for the result fields.
  function automatic logic [15:0] to_field16(input offset_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/script_token_lexer_core.sv =====
// ---------------------------------------------------------------------------
// script_token_lexer_core - streaming lexer for a small scripting language
// Takes one source byte per transaction and emits zero, one or two tokens.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one source byte per
//   transaction. A byte of zero or end_of_input set flushes the pending token,
//   emits an end token and returns the scanner to its reset state.
//   Result channel (out_valid / out_stall / out_data): tokens in source order,
//   last_of_run marking the final token caused by one input byte.
//   Latency: a token is queued the cycle after the byte that ends it.
//   Throughput: one byte per cycle while in_stall is low. The scanner state
//   updates on each accepted byte; the limit is the single-token-per-cycle
//   result port, so a byte producing two tokens is presented one at a time.
//   A three-entry result queue lets a new byte in while up to one token is
//   still waiting. in_stall rises while the queue holds two or more tokens.
//   When the receiver stalls, the queue holds its contents and out_data stays
//   put; input stalls once the queue can no longer take a two-token byte.
//   Reset (rst_n low, synchronous): mode idle, position zero, queue empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module script_token_lexer_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire stl_pkg::lex_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output stl_pkg::lex_out_t     out_data
);

  localparam int QDEPTH = 3;

  // Scanner state
  logic [2:0]       mode_r,  mode_nxt;
  stl_pkg::offset_t pos_r,   pos_nxt;
  stl_pkg::offset_t start_r, start_nxt;
  logic [2:0]       km_r,    km_nxt;

  // Result queue
  stl_pkg::lex_out_t q_r   [QDEPTH];
  stl_pkg::lex_out_t q_nxt [QDEPTH];
  logic [1:0]        cnt_r, cnt_nxt;

  logic in_acc;
  logic pop;
  logic eoi;
  logic [7:0] c;

  stl_pkg::offset_t pend_len;
  stl_pkg::offset_t pos_adv;
  logic             pos_max;
  logic [2:0]       hit_cont;
  logic [2:0]       hit_new;

  logic              fl_valid;
  stl_pkg::lex_out_t fl_tok;
  logic              one_valid;
  stl_pkg::lex_out_t one_tok;
  stl_pkg::lex_out_t end_tok;
  stl_pkg::lex_out_t r0, r1;
  logic [1:0]        nres;
  logic [1:0]        cnt_after;

  // Accept while the queue can still take a two-token byte
  assign in_stall  = cnt_r[1];
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;

  assign c   = in_data.src_byte;
  assign eoi = in_data.end_of_input || (c == stl_pkg::CH_NUL);

  assign pend_len = pos_r - start_r;
  assign pos_max  = (pos_r == '1);
  // Saturate the offset at its maximum
  assign pos_adv  = pos_max ? pos_r : pos_r + stl_pkg::offset_t'(1);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit_cont[k] = stl_pkg::kw_hit(2'(k), pend_len, c);
      hit_new[k]  = stl_pkg::kw_hit(2'(k), '0, c);
    end
  end

  // Token that the pending scan mode would produce if ended now
  always_comb begin
    fl_valid = 1'b1;
    fl_tok   = '0;
    fl_tok.token_start  = stl_pkg::to_field16(start_r);
    fl_tok.token_length = stl_pkg::to_field16(pend_len);
    fl_tok.value_type   = stl_pkg::VT_NONE;
    unique case (mode_r)
      stl_pkg::MODE_IDENT: begin
        // First surviving keyword of matching length wins
        if (km_r[stl_pkg::KW_LOCAL] && pend_len == stl_pkg::offset_t'(5)) begin
          fl_tok.token_kind = stl_pkg::TOK_LOCAL;
        end else if (km_r[stl_pkg::KW_INT] && pend_len == stl_pkg::offset_t'(3)) begin
          fl_tok.token_kind = stl_pkg::TOK_TYPE;
          fl_tok.value_type = stl_pkg::VT_INT;
        end else if (km_r[stl_pkg::KW_FLOAT] && pend_len == stl_pkg::offset_t'(5)) begin
          fl_tok.token_kind = stl_pkg::TOK_TYPE;
          fl_tok.value_type = stl_pkg::VT_FLOAT;
        end else begin
          fl_tok.token_kind = stl_pkg::TOK_IDENT;
        end
      end
      stl_pkg::MODE_INT:  fl_tok.token_kind = stl_pkg::TOK_NUMBER;
      stl_pkg::MODE_FRAC: fl_tok.token_kind = stl_pkg::TOK_DECIMAL;
      stl_pkg::MODE_DASH: fl_tok.token_kind = stl_pkg::TOK_MINUS;
      default: begin
        fl_valid          = 1'b0;
        fl_tok.token_kind = stl_pkg::TOK_END;
      end
    endcase
  end

  // Single-character token for a byte handled from idle
  always_comb begin
    one_tok = '0;
    one_tok.token_start  = stl_pkg::to_field16(pos_r);
    one_tok.token_length = 16'd1;
    one_tok.value_type   = stl_pkg::VT_NONE;
    case (c)
      stl_pkg::CH_EQ:     one_tok.token_kind = stl_pkg::TOK_ASSIGN;
      stl_pkg::CH_PLUS:   one_tok.token_kind = stl_pkg::TOK_PLUS;
      stl_pkg::CH_STAR:   one_tok.token_kind = stl_pkg::TOK_STAR;
      stl_pkg::CH_SLASH:  one_tok.token_kind = stl_pkg::TOK_SLASH;
      stl_pkg::CH_LPAREN: one_tok.token_kind = stl_pkg::TOK_LPAREN;
      stl_pkg::CH_RPAREN: one_tok.token_kind = stl_pkg::TOK_RPAREN;
      stl_pkg::CH_COLON:  one_tok.token_kind = stl_pkg::TOK_COLON;
      default:            one_tok.token_kind = stl_pkg::TOK_ERROR;
    endcase
  end

  always_comb begin
    end_tok = '0;
    end_tok.token_kind   = stl_pkg::TOK_END;
    end_tok.value_type   = stl_pkg::VT_NONE;
    end_tok.token_start  = stl_pkg::to_field16(pos_r);
    end_tok.token_length = 16'd0;
    end_tok.last_of_run  = 1'b1;
  end

  // Per-byte scanner step
  always_comb begin
    logic cont;
    cont      = 1'b0;
    one_valid = 1'b0;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    km_nxt    = km_r;
    r0        = fl_tok;
    r1        = end_tok;
    nres      = 2'd0;

    if (eoi) begin
      // Flush the pending token, then the end token; back to reset state
      if (fl_valid) begin
        r0   = fl_tok;
        r0.last_of_run = 1'b0;
        r1   = end_tok;
        nres = 2'd2;
      end else begin
        r0   = end_tok;
        nres = 2'd1;
      end
      mode_nxt  = stl_pkg::MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      km_nxt    = 3'b111;
    end else begin
      unique case (mode_r)
        stl_pkg::MODE_IDENT: begin
          if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
            cont   = 1'b1;
            km_nxt = pos_max ? 3'b000 : (km_r & hit_cont);
          end
        end
        stl_pkg::MODE_INT: begin
          if (stl_pkg::is_digit(c)) begin
            cont = 1'b1;
          end else if (c == stl_pkg::CH_DOT) begin
            cont     = 1'b1;
            mode_nxt = stl_pkg::MODE_FRAC;
          end
        end
        stl_pkg::MODE_FRAC: begin
          if (stl_pkg::is_digit(c)) begin
            cont = 1'b1;
          end
        end
        stl_pkg::MODE_DASH: begin
          if (c == stl_pkg::CH_DASH) begin
            cont     = 1'b1;
            mode_nxt = stl_pkg::MODE_COMMENT;
          end
        end
        stl_pkg::MODE_COMMENT: begin
          cont = 1'b1;
          if (c == stl_pkg::CH_NL) begin
            mode_nxt = stl_pkg::MODE_IDLE;
          end
        end
        default: cont = 1'b0;
      endcase

      if (cont) begin
        pos_nxt = pos_adv;
      end else begin
        // Byte ends any pending token, then starts afresh from idle
        mode_nxt = stl_pkg::MODE_IDLE;
        pos_nxt  = pos_adv;
        if (!stl_pkg::is_space(c)) begin
          start_nxt = pos_r;
          if (stl_pkg::is_alpha(c) || c == stl_pkg::CH_UNDER) begin
            mode_nxt = stl_pkg::MODE_IDENT;
            km_nxt   = pos_max ? 3'b000 : hit_new;
          end else if (stl_pkg::is_digit(c)) begin
            mode_nxt = stl_pkg::MODE_INT;
          end else if (c == stl_pkg::CH_DASH) begin
            mode_nxt = stl_pkg::MODE_DASH;
          end else begin
            one_valid = 1'b1;
          end
        end

        if (fl_valid && one_valid) begin
          r0   = fl_tok;
          r0.last_of_run = 1'b0;
          r1   = one_tok;
          r1.last_of_run = 1'b1;
          nres = 2'd2;
        end else if (fl_valid) begin
          r0   = fl_tok;
          r0.last_of_run = 1'b1;
          nres = 2'd1;
        end else if (one_valid) begin
          r0   = one_tok;
          r0.last_of_run = 1'b1;
          nres = 2'd1;
        end
      end
    end
  end

  // Queue: shift out on pop, append this transaction's tokens behind
  always_comb begin
    cnt_after = cnt_r - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (in_acc && nres != 2'd0 && 2'(i) == cnt_after) begin
        q_nxt[i] = r0;
      end
      if (in_acc && nres == 2'd2 && 2'(i) == cnt_after + 2'd1) begin
        q_nxt[i] = r1;
      end
    end
    cnt_nxt = cnt_after + (in_acc ? nres : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stl_pkg::MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      km_r    <= 3'b111;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        mode_r  <= mode_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        km_r    <= km_nxt;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // An end-of-input transaction leaves the scanner in its reset state
  `STL_ASSERT_NXT(a_eoi_clears, in_acc && eoi, mode_r == stl_pkg::MODE_IDLE && pos_r == '0)
  // Position only moves forward between end-of-input transactions
  `STL_ASSERT_NXT(a_pos_forward, in_acc && !eoi, pos_r >= $past(pos_r))
  // A non-final token always has its companion queued behind it
  `STL_ASSERT_IMP(a_pair_kept, out_valid && !out_data.last_of_run, cnt_r >= 2'd2)

endmodule

`default_nettype wire
